// ----- rtl/lhu_pkg.sv -----
// ============================================================================
// lhu_pkg
// Shared types and constants for the latency histogram unit.
// ============================================================================
`default_nettype none

package lhu_pkg;

    // operation codes carried by the mode field
    typedef enum logic [1:0] {
        MODE_RECORD = 2'd0,
        MODE_READ   = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    // configuration register index (paddr[2])
    localparam logic REG_CYCLES_PER_NS = 1'b0;

    localparam int DIV_STEPS = 64;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // latch input item
        logic div_step;   // one quotient bit
        logic bin_load;   // quotient -> bin address
        logic upd;        // saturating increment, write back
        logic scan_next;  // advance scan pointer
        logic scan_hit;   // current bin is the result
        logic res_zero;   // all-zero result
        logic clr_wr;     // zero one bin, advance pointer
        logic out_load;   // pending result -> output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_last;   // final quotient bit this cycle
        logic addr_last;  // pointer at last bin
        logic rd_zero;    // fetched count is zero
        logic oob;        // read start beyond last bin
        logic out_free;   // output register can take a result
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/latency_histogram_unit.sv -----
// ============================================================================
// latency_histogram_unit
// Histogram of latencies with saturating bins and an overflow bin.
// ============================================================================
// Input channel (i_valid/o_ready) takes one operation per transfer: record
// a sample, read the next nonzero bin from i_read_from, or clear all bins.
// Every input transfer yields exactly one output transfer (o_valid/i_ready).
// cycles_per_ns sits at APB address 0; a written zero acts as one.
// Operations, from input transfer to result in the output register:
//   record : bit-serial division over all 64 quotient bits, then bin load, read, saturating write back
//   read   : bins examined in turn, one bin memory read port
//   clear  : one bin zeroed per cycle
//   mode 3 : no-op with an all-zero result
// One operation is in flight at a time; o_ready is high only between them.
// The output register frees the controller: a new input transfer is taken
// while one result waits, and a second result waits in the datapath until
// the receiver takes the first.
// After reset the bin memory is zeroed in a pass over all BINS bins,
// during which o_ready stays low; APB writes are taken throughout.
// ============================================================================
`default_nettype none

module latency_histogram_unit
    import lhu_pkg::*;
#(
    parameter int BINS       = 4096,
    parameter int COUNT_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [63:0] i_start_stamp,
    input  wire logic [63:0] i_end_stamp,
    input  wire logic [11:0] i_read_from,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_found,
    output logic [11:0]      o_bin_index,
    output logic [31:0]      o_bin_count
);

    logic [7:0] r_cycles_per_ns;
    logic       n_cfg_wr;
    t_cmd       cmd;
    t_sts       sts;

    assign n_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CYCLES_PER_NS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycles_per_ns <= 8'd1;
        end else if (n_cfg_wr) begin
            r_cycles_per_ns <= pwdata[7:0];
        end
    end

    // byte offset bits are ignored on reads
    assign prdata = (paddr[2] == REG_CYCLES_PER_NS) ? {24'd0, r_cycles_per_ns} : 32'd0;
    assign pready = 1'b1;

    lhu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lhu_dp #(
        .BINS       (BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cycles_per_ns (r_cycles_per_ns),
        .i_mode          (i_mode),
        .i_start_stamp   (i_start_stamp),
        .i_end_stamp     (i_end_stamp),
        .i_read_from     (i_read_from),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_found         (o_found),
        .o_bin_index     (o_bin_index),
        .o_bin_count     (o_bin_count)
    );

endmodule

`default_nettype wire

// ----- rtl/lhu_dp.sv -----
// ============================================================================
// lhu_dp
// Datapath: restoring divider, bin memory, scan/clear pointer, result regs.
// ============================================================================
`default_nettype none

module lhu_dp
    import lhu_pkg::*;
#(
    parameter int BINS       = 4096,
    parameter int COUNT_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic [7:0]  i_cycles_per_ns,
    input  wire logic [1:0]  i_mode,
    input  wire logic [63:0] i_start_stamp,
    input  wire logic [63:0] i_end_stamp,
    input  wire logic [11:0] i_read_from,
    input  wire logic        i_ready,
    output logic             o_valid,
    output logic             o_found,
    output logic [11:0]      o_bin_index,
    output logic [31:0]      o_bin_count
);

    localparam int IDX_W = $clog2(BINS);
    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(BINS - 1);
    localparam logic [63:0]           LAST_BIN  = 64'(BINS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    logic [COUNT_BITS-1:0] mem [BINS];

    logic [63:0]           r_quo;
    logic [7:0]            r_rem;
    logic [7:0]            r_div;
    logic [STEP_W-1:0]     r_step;
    logic [IDX_W-1:0]      r_addr;
    logic                  r_oob;
    logic [COUNT_BITS-1:0] r_rd_data;

    logic                  r_p_found;
    logic [IDX_W-1:0]      r_p_idx;
    logic [COUNT_BITS-1:0] r_p_cnt;

    logic                  r_o_valid;
    logic                  r_o_found;
    logic [11:0]           r_o_idx;
    logic [31:0]           r_o_cnt;

    logic [8:0]            n_trial;
    logic                  n_qbit;
    logic [8:0]            n_diff;
    logic [COUNT_BITS-1:0] n_count;
    logic                  n_we;
    logic [COUNT_BITS-1:0] n_wdata;
    logic [31:0]           n_idx_ext;
    logic [63:0]           n_cnt_ext;

    // restoring division step
    always_comb begin
        n_trial = {r_rem, r_quo[63]};
        n_qbit  = (n_trial >= {1'b0, r_div});
        n_diff  = n_trial - {1'b0, r_div};
    end

    assign n_count   = (r_rd_data == COUNT_MAX) ? r_rd_data : r_rd_data + 1'b1;
    assign n_we      = i_cmd.upd | i_cmd.clr_wr;
    assign n_wdata   = i_cmd.upd ? n_count : '0;
    assign n_idx_ext = 32'(r_p_idx);
    assign n_cnt_ext = 64'(r_p_cnt);

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            mem[r_addr] <= n_wdata;
        end
        r_rd_data <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_quo  <= i_end_stamp - i_start_stamp;
            r_rem  <= '0;
            r_step <= '0;
            r_div  <= (i_cycles_per_ns == 8'd0) ? 8'd1 : i_cycles_per_ns;
            r_oob  <= (32'(i_read_from) >= 32'(BINS));
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[62:0], n_qbit};
            r_rem  <= n_qbit ? n_diff[7:0] : n_trial[7:0];
            r_step <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.accept) begin
            r_addr <= (t_mode'(i_mode) == MODE_READ) ? IDX_W'(i_read_from) : '0;
        end else if (i_cmd.bin_load) begin
            r_addr <= (r_quo >= LAST_BIN) ? LAST_IDX : r_quo[IDX_W-1:0];
        end else if (i_cmd.scan_next || i_cmd.clr_wr) begin
            r_addr <= r_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_zero) begin
            r_p_found <= 1'b0;
            r_p_idx   <= '0;
            r_p_cnt   <= '0;
        end else if (i_cmd.upd) begin
            r_p_found <= 1'b0;
            r_p_idx   <= r_addr;
            r_p_cnt   <= n_count;
        end else if (i_cmd.scan_hit) begin
            r_p_found <= 1'b1;
            r_p_idx   <= r_addr;
            r_p_cnt   <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_found <= r_p_found;
            r_o_idx   <= n_idx_ext[11:0];
            r_o_cnt   <= n_cnt_ext[31:0];
        end
    end

    always_comb begin
        o_sts.div_last  = (r_step == LAST_STEP);
        o_sts.addr_last = (r_addr == LAST_IDX);
        o_sts.rd_zero   = (r_rd_data == '0);
        o_sts.oob       = r_oob;
        o_sts.out_free  = !r_o_valid || i_ready;
    end

    assign o_valid     = r_o_valid;
    assign o_found     = r_o_found;
    assign o_bin_index = r_o_idx;
    assign o_bin_count = r_o_cnt;

endmodule

`default_nettype wire

// ----- rtl/lhu_ctrl.sv -----
// ============================================================================
// lhu_ctrl
// Controller: sequences record, read-scan, clear and the reset clearing pass.
// ============================================================================
`default_nettype none

module lhu_ctrl
    import lhu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_mode,
    output logic            o_ready,
    input  wire t_sts       i_sts,
    output t_cmd            o_cmd
);

    typedef enum logic [9:0] {
        ST_INIT   = 10'b00_0000_0001,
        ST_IDLE   = 10'b00_0000_0010,
        ST_DIV    = 10'b00_0000_0100,
        ST_BIN    = 10'b00_0000_1000,
        ST_FETCH  = 10'b00_0001_0000,
        ST_UPD    = 10'b00_0010_0000,
        ST_SCAN_F = 10'b00_0100_0000,
        ST_SCAN_C = 10'b00_1000_0000,
        ST_CLR    = 10'b01_0000_0000,
        ST_DONE   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.addr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (t_mode'(i_mode))
                        MODE_RECORD: n_state = ST_DIV;
                        MODE_READ:   n_state = ST_SCAN_F;
                        MODE_CLEAR:  n_state = ST_CLR;
                        default: begin
                            o_cmd.res_zero = 1'b1;
                            n_state        = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = ST_BIN;
            end
            ST_BIN: begin
                o_cmd.bin_load = 1'b1;
                n_state        = ST_FETCH;
            end
            ST_FETCH: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = ST_DONE;
            end
            ST_SCAN_F: begin
                // bin read issues this cycle
                if (i_sts.oob) begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    n_state = ST_SCAN_C;
                end
            end
            ST_SCAN_C: begin
                if (!i_sts.rd_zero) begin
                    o_cmd.scan_hit = 1'b1;
                    n_state        = ST_DONE;
                end else if (i_sts.addr_last) begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = ST_SCAN_F;
                end
            end
            ST_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.addr_last) begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- test/latency_histogram_unit_tb.sv -----
// ----------------------------------------------------------------------------
// latency_histogram_unit_tb
// Self-checking bench for the latency histogram unit. A queue-fed driver
// offers record, read, clear and no-op items, a monitor compares every
// result with a bin-level model of the histogram, and the divisor is
// reprogrammed over APB between phases while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module latency_histogram_unit_tb;
    import lhu_pkg::*;

    localparam int          NUM_BINS  = 4096;
    localparam logic [31:0] COUNT_TOP = 32'hFFFF_FFFF;
    localparam logic [1:0]  MODE_NOP  = 2'd3;
    localparam int          PHASE_OPS = 150;
    localparam int          HOLD_AT   = 120;
    localparam int          HOLD_LEN  = 600;

    typedef struct {
        logic [1:0]  mode;
        logic [63:0] start_stamp;
        logic [63:0] end_stamp;
        logic [11:0] read_from;
    } op_item_t;

    typedef struct {
        logic        found;
        logic [11:0] bin_index;
        logic [31:0] bin_count;
    } bin_report_t;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_mode        = '0;
    logic [63:0] i_start_stamp = '0;
    logic [63:0] i_end_stamp   = '0;
    logic [11:0] i_read_from   = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_found;
    logic [11:0] o_bin_index;
    logic [31:0] o_bin_count;

    latency_histogram_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_start_stamp (i_start_stamp),
        .i_end_stamp   (i_end_stamp),
        .i_read_from   (i_read_from),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_found       (o_found),
        .o_bin_index   (o_bin_index),
        .o_bin_count   (o_bin_count)
    );

    // histogram model state
    logic [31:0] bin_tally [NUM_BINS];
    logic [7:0]  divisor_reg = 8'd1;

    op_item_t    pending_ops [$];
    bin_report_t report_q [$];
    op_item_t    cur_op;

    int  queued_cnt   = 0;
    int  accepted_cnt = 0;
    int  results_seen = 0;
    int  fail_cnt     = 0;
    int  gap_left     = 0;
    int  stall_left   = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;
    bit  calm         = 1'b0;

    initial begin
        foreach (bin_tally[k]) bin_tally[k] = '0;
    end

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] eff_divisor();
        return (divisor_reg == 8'd0) ? 64'd1 : {56'd0, divisor_reg};
    endfunction

    // apply one operation to the model histogram and return its report
    function automatic bin_report_t apply_op(input op_item_t op);
        bin_report_t res;
        logic [63:0] ns;
        int unsigned bin;
        int unsigned pos;
        res.found     = 1'b0;
        res.bin_index = '0;
        res.bin_count = '0;
        case (op.mode)
            MODE_RECORD: begin
                ns  = (op.end_stamp - op.start_stamp) / eff_divisor();
                bin = (ns >= 64'(NUM_BINS - 1)) ? NUM_BINS - 1 : int'(ns);
                if (bin_tally[bin] != COUNT_TOP) bin_tally[bin] = bin_tally[bin] + 32'd1;
                res.bin_index = bin[11:0];
                res.bin_count = bin_tally[bin];
            end
            MODE_READ: begin
                pos = op.read_from;
                while (pos < NUM_BINS && bin_tally[pos] == 32'd0) pos++;
                if (pos < NUM_BINS) begin
                    res.found     = 1'b1;
                    res.bin_index = pos[11:0];
                    res.bin_count = bin_tally[pos];
                end
            end
            MODE_CLEAR: begin
                foreach (bin_tally[k]) bin_tally[k] = '0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic push_op(input op_item_t op);
        pending_ops.push_back(op);
        queued_cnt++;
    endtask

    task automatic push_record(input logic [63:0] start_stamp, input logic [63:0] end_stamp);
        op_item_t op;
        op.mode        = MODE_RECORD;
        op.start_stamp = start_stamp;
        op.end_stamp   = end_stamp;
        op.read_from   = 12'($urandom);
        push_op(op);
    endtask

    task automatic push_simple(input logic [1:0] mode, input logic [11:0] read_from);
        op_item_t op;
        op.mode        = mode;
        op.start_stamp = {$urandom, $urandom};
        op.end_stamp   = {$urandom, $urandom};
        op.read_from   = read_from;
        push_op(op);
    endtask

    task automatic push_random_ops(input int count);
        op_item_t    op;
        logic [63:0] span;
        logic [63:0] d;
        int          pick;
        for (int n = 0; n < count; n++) begin
            op.mode        = 2'($urandom);
            op.start_stamp = {$urandom, $urandom};
            op.end_stamp   = {$urandom, $urandom};
            op.read_from   = 12'($urandom);
            pick = $urandom_range(0, 99);
            d    = eff_divisor();
            if (pick < 55) begin
                op.mode = MODE_RECORD;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: span = 64'($urandom_range(0, 63)) * d;
                    5, 6, 7, 8:    span = 64'($urandom_range(0, NUM_BINS - 2)) * d;
                    default: begin
                        if ($urandom_range(0, 1) == 0)
                            span = 64'($urandom_range(NUM_BINS - 1, 5000)) * d;
                        else
                            span = {$urandom, $urandom};
                    end
                endcase
                // remainder below the divisor must not move the bin
                span = span + 64'($urandom_range(0, int'(d) - 1));
                op.end_stamp = op.start_stamp + span;
            end else if (pick < 92) begin
                op.mode = MODE_READ;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: op.read_from = 12'($urandom_range(0, 127));
                    6, 7, 8:          op.read_from = 12'($urandom_range(0, NUM_BINS - 1));
                    default:          op.read_from = 12'($urandom_range(NUM_BINS - 8,
                                                                        NUM_BINS - 1));
                endcase
            end else if (pick < 98) begin
                op.mode = MODE_NOP;
            end else begin
                op.mode = MODE_CLEAR;
            end
            push_op(op);
        end
    endtask

    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || report_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_divisor(input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CYCLES_PER_NS, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        divisor_reg = value[7:0];
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                accepted_cnt++;
                report_q.push_back(apply_op(cur_op));
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_ops.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 3);
                    i_valid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    cur_op = pending_ops.pop_front();
                    i_valid       <= 1'b1;
                    i_mode        <= cur_op.mode;
                    i_start_stamp <= cur_op.start_stamp;
                    i_end_stamp   <= cur_op.end_stamp;
                    i_read_from   <= cur_op.read_from;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge i_clk) begin
        bin_report_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (report_q.size() == 0) begin
                    $display("%0t: result with nothing pending: found %0b index %0d count %0d",
                             $time, o_found, o_bin_index, o_bin_count);
                    fail_cnt++;
                end else begin
                    want = report_q.pop_front();
                    check_field("found", 64'(want.found), 64'(o_found));
                    check_field("bin_index", 64'(want.bin_index), 64'(o_bin_index));
                    check_field("bin_count", 64'(want.bin_count), 64'(o_bin_count));
                end
            end
            // one long hold-off so the unit backs up into its input
            if (!hold_done && results_seen == HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 3);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        #120000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        logic [31:0] divisors [7];
        divisors[0] = 32'd255;
        divisors[1] = 32'd1;
        divisors[2] = 32'($urandom_range(2, 254));
        divisors[3] = 32'd0;
        divisors[4] = $urandom;
        divisors[5] = 32'd128;
        divisors[6] = 32'd1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset divisor of one: empty reads, bin edges, stamp wrap, clear
        push_simple(MODE_READ, 12'd0);
        push_simple(MODE_READ, 12'd4095);
        push_record(64'd1000, 64'd1000);
        push_record(64'd1000, 64'd1001);
        push_record(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0FFE);
        push_record(64'd0, 64'd4095);
        push_record(64'd0, 64'd4096);
        push_record(64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        push_record(64'd1, 64'd0);
        push_record(64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        push_record(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        push_simple(MODE_READ, 12'd0);
        push_simple(MODE_READ, 12'd2);
        push_simple(MODE_READ, 12'd4095);
        push_simple(MODE_NOP, 12'hFFF);
        push_simple(MODE_CLEAR, 12'hAAA);
        push_simple(MODE_READ, 12'd0);
        push_record(64'h0123_4567_89AB_CDEF, 64'h0123_4567_89AB_CDF4);
        push_simple(MODE_READ, 12'd1);
        wait_drained();

        // zero divisor acts as one
        write_divisor(32'd0);
        push_record(64'd10, 64'd13);
        push_simple(MODE_READ, 12'd0);
        wait_drained();

        // widest divisor: quotient truncation at both ends of the range
        write_divisor(32'd255);
        push_record(64'd0, 64'd254);
        push_record(64'd0, 64'd255);
        push_record(64'd0, 64'd255 * 64'd4095);
        push_record(64'd0, 64'd255 * 64'd4095 - 64'd1);
        push_simple(MODE_READ, 12'd0);
        wait_drained();

        for (int p = 0; p < 7; p++) begin
            write_divisor(divisors[p]);
            if (p == 6) calm = 1'b1;
            push_random_ops(PHASE_OPS);
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
